// File: src/stp_pkg.sv
`timescale 1ns / 1ps

package stp_pkg;

    localparam int STEP_COUNT_BITS_DEF = 24;
    localparam int TIMER_BITS_DEF      = 32;

    localparam int PERIOD_W  = 24;
    localparam int TIMEOUT_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int FIELD_STEPS_W = 24;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 24'd1000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd2000000;

    typedef enum logic {
        REG_STEP_PERIOD  = 1'b0,
        REG_IDLE_TIMEOUT = 1'b1
    } stp_reg_idx_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_MOVE = 1'b1
    } stp_kind_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]  step_period;
        logic [TIMEOUT_W-1:0] idle_timeout;
    } stp_cfg_t;

endpackage

// File: src/stp_cfg_regs.sv
`timescale 1ns / 1ps

module stp_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  stp_pkg::stp_reg_idx_t             cfg_addr,
    input  logic [stp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output stp_pkg::stp_cfg_t                 cfg
);

    logic [stp_pkg::PERIOD_W-1:0]  period_reg;
    logic [stp_pkg::TIMEOUT_W-1:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= stp_pkg::PERIOD_RESET;
            timeout_reg <= stp_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                stp_pkg::REG_STEP_PERIOD:
                begin
                    period_reg <= cfg_wdata[stp_pkg::PERIOD_W-1:0];
                end
                stp_pkg::REG_IDLE_TIMEOUT:
                begin
                    timeout_reg <= cfg_wdata[stp_pkg::TIMEOUT_W-1:0];
                end
                default:
                begin
                    period_reg <= period_reg;
                end
            endcase
        end
    end

    assign cfg.step_period  = period_reg;
    assign cfg.idle_timeout = timeout_reg;

endmodule

// File: src/stepper_step_dir_generator_top.sv
`timescale 1ns / 1ps
// Channel   | Dir | Handshake         | Payload
// s_*       | in  | tvalid / tready   | tuser = kind, tdata = move_steps
// m_*       | out | tvalid / tready   | tdata = step, dir, enable, steps_left, idle
// cfg_*     | in  | cfg_we, no wait   | cfg_addr = register index, cfg_wdata
//
// One item per clock while the result register is free or taken: each accepted
// item updates the state and loads the result register in the same cycle.
// The input side stalls only while the result register is full and not taken.
// Reset (rst_n, async low) clears state and result valid, sets since_edge to max.

module stepper_step_dir_generator_top
#(
    parameter int STEP_COUNT_BITS = stp_pkg::STEP_COUNT_BITS_DEF,
    parameter int TIMER_BITS      = stp_pkg::TIMER_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [23:0] move_steps
    input  logic                           s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [0] step_out, [1] dir_out,
                                                      // [2] enable_out, [26:3] steps_left,
                                                      // [27] idle, [31:28] zero
    input  logic                           cfg_we,
    input  stp_pkg::stp_reg_idx_t          cfg_addr,
    input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int FW = stp_pkg::FIELD_STEPS_W;
    localparam int W  = (STEP_COUNT_BITS > FW) ? STEP_COUNT_BITS : FW;
    localparam int CW = (TIMER_BITS > stp_pkg::TIMEOUT_W) ? TIMER_BITS : stp_pkg::TIMEOUT_W;
    localparam logic signed [W-1:0] CMAX =
        {{(W-STEP_COUNT_BITS+1){1'b0}}, {(STEP_COUNT_BITS-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = ~CMAX;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    stp_pkg::stp_cfg_t cfg;

    stp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic signed [STEP_COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic [TIMER_BITS-1:0]             since_edge_reg, since_edge_next;
    logic [TIMER_BITS-1:0]             idle_elapsed_reg, idle_elapsed_next;
    logic                              pulse_reg, pulse_next;
    logic                              dir_reg, dir_next;
    logic                              idle_reg, idle_next;
    logic                              enable_reg, enable_next;
    logic                              m_tvalid_reg;
    logic [31:0]                       m_tdata_reg;

    logic                              accept;
    logic signed [W-1:0]               load_ext;
    logic signed [STEP_COUNT_BITS-1:0] load_val;
    logic [TIMER_BITS-1:0]             se_inc;
    logic [TIMER_BITS-1:0]             ie_inc;
    logic                              past_period;
    logic                              past_half;
    logic                              past_timeout;
    logic signed [W-1:0]               rem_out_ext;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        load_ext = W'($signed(s_tdata));
        if (load_ext > CMAX)
        begin
            load_ext = CMAX;
        end
        else if (load_ext < CMIN)
        begin
            load_ext = CMIN;
        end
        load_val = load_ext[STEP_COUNT_BITS-1:0];
    end

    assign se_inc = (since_edge_reg == TMAX) ? TMAX : since_edge_reg + 1'b1;
    assign ie_inc = (idle_elapsed_reg == TMAX) ? TMAX : idle_elapsed_reg + 1'b1;
    assign past_period  = CW'(se_inc) > CW'(cfg.step_period);
    assign past_half    = CW'(se_inc) > CW'(cfg.step_period >> 1);
    assign past_timeout = CW'(ie_inc) > CW'(cfg.idle_timeout);

    always_comb
    begin
        remaining_next    = remaining_reg;
        since_edge_next   = since_edge_reg;
        idle_elapsed_next = idle_elapsed_reg;
        pulse_next        = pulse_reg;
        dir_next          = dir_reg;
        idle_next         = idle_reg;
        enable_next       = enable_reg;
        if (s_tuser == stp_pkg::KIND_MOVE)
        begin
            remaining_next = load_val;
        end
        else
        begin
            since_edge_next = se_inc;
            if (remaining_reg == '0)
            begin
                if (idle_reg)
                begin
                    idle_elapsed_next = ie_inc;
                    if (past_timeout)
                    begin
                        enable_next = 1'b1;
                    end
                end
                else
                begin
                    idle_next         = 1'b1;
                    idle_elapsed_next = '0;
                end
                if (pulse_reg && past_half)
                begin
                    pulse_next = 1'b0;
                end
            end
            else
            begin
                idle_next   = 1'b0;
                enable_next = 1'b0;
                dir_next    = !remaining_reg[STEP_COUNT_BITS-1];
                if (past_period)
                begin
                    since_edge_next = '0;
                    pulse_next      = 1'b1;
                    if (remaining_reg[STEP_COUNT_BITS-1])
                    begin
                        remaining_next = remaining_reg + 1'b1;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 1'b1;
                    end
                end
                else if (pulse_reg && past_half)
                begin
                    pulse_next = 1'b0;
                end
            end
        end
    end

    assign rem_out_ext = W'(remaining_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg    <= '0;
            since_edge_reg   <= TMAX;
            idle_elapsed_reg <= '0;
            pulse_reg        <= 1'b0;
            dir_reg          <= 1'b0;
            idle_reg         <= 1'b0;
            enable_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                remaining_reg    <= remaining_next;
                since_edge_reg   <= since_edge_next;
                idle_elapsed_reg <= idle_elapsed_next;
                pulse_reg        <= pulse_next;
                dir_reg          <= dir_next;
                idle_reg         <= idle_next;
                enable_reg       <= enable_next;
                m_tvalid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {4'b0000, idle_next, rem_out_ext[FW-1:0],
                            enable_next, dir_next, pulse_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
